FILE: src/cmc_pkg.sv
// package: widths and payload types for the corrected mass pipeline
`timescale 1ns / 1ps
`default_nettype none
package cmc_pkg;

  localparam int POS_WIDTH = 24;
  localparam int MOM_WIDTH = 32;

  localparam int DW     = POS_WIDTH + 1;       // vertex difference and its magnitude
  localparam int MSB_W  = $clog2(DW);
  localparam int NORM_W = 30;                  // normalized magnitude, msb at bit 29
  localparam int UFRAC  = 20;
  localparam int L2_W   = 2 * NORM_W + 2;
  localparam int LEN_W  = L2_W / 2;
  localparam int U_W    = UFRAC + 1;           // unit vector magnitude, up to 2^20
  localparam int DIVW   = NORM_W + UFRAC + 1;
  localparam int PR_W   = U_W + 1 + MOM_WIDTH;
  localparam int DOT_W  = PR_W + 2;
  localparam int DD_W   = DOT_W - UFRAC + 1;
  localparam int TP_W   = DD_W + U_W + 1;
  localparam int RM_W   = MOM_WIDTH + 2;
  localparam int PT2_W  = 2 * RM_W + 2;
  localparam int P2_W   = 2 * MOM_WIDTH + 2;
  localparam int M2_W   = 2 * MOM_WIDTH;
  localparam int X_W    = 2 * MOM_WIDTH + 8;
  localparam int R_W    = X_W / 2;

  localparam int CM_W = 34;
  localparam int PT_W = 33;
  localparam logic [63:0] CM_MAX = (64'd1 << CM_W) - 64'd1;
  localparam logic [63:0] PT_MAX = (64'd1 << PT_W) - 64'd1;

  typedef struct packed {
    logic signed [POS_WIDTH-1:0] pv_x;
    logic signed [POS_WIDTH-1:0] pv_y;
    logic signed [POS_WIDTH-1:0] pv_z;
    logic signed [POS_WIDTH-1:0] sv_x;
    logic signed [POS_WIDTH-1:0] sv_y;
    logic signed [POS_WIDTH-1:0] sv_z;
    logic signed [MOM_WIDTH-1:0] mom_x;
    logic signed [MOM_WIDTH-1:0] mom_y;
    logic signed [MOM_WIDTH-1:0] mom_z;
    logic [MOM_WIDTH-1:0]        energy;
  } in_t;

  typedef struct packed {
    logic [CM_W-1:0] corrected_mass;
    logic [PT_W-1:0] missing_pt;
    logic            mass_clamped;
  } out_t;

  // momentum side data that rides along the direction pipeline
  typedef struct packed {
    logic [2:0]                  neg;
    logic                        zero;
    logic [2:0][MOM_WIDTH-1:0]   p;
    logic [MOM_WIDTH-1:0]        e;
  } carry_t;

  typedef struct packed {
    logic [L2_W-1:0]          rem;
    logic [LEN_W-1:0]         root;
    logic [2:0][NORM_W-1:0]   n;
    carry_t                   c;
  } lsq_t;

  typedef struct packed {
    logic [2:0][DIVW-1:0]     rem;
    logic [2:0][U_W-1:0]      q;
    logic [LEN_W-1:0]         len;
    carry_t                   c;
  } dsq_t;

  typedef struct packed {
    logic [1:0][X_W-1:0]      rem;
    logic [1:0][R_W-1:0]      root;
    logic                     clamped;
  } rsq_t;

endpackage
`default_nettype wire

FILE: src/corrected_mass_calc_core.sv
// corrected mass and missing pt pipeline, one candidate per cycle
// stages from start to valid_o: 3 setup stages, 31-stage flight
//   length square root, 22-stage divider, 7 momentum stages, 36-stage square root, output
// throughput: one word per cycle; busy is always low, the pipeline never stalls
// every result is shown for one cycle on valid_o
// reset clears the valid bits only; data registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module corrected_mass_calc_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire cmc_pkg::in_t  data_i,
  output logic               valid_o,
  output cmc_pkg::out_t      result_o
);

  localparam int MOM     = cmc_pkg::MOM_WIDTH;
  localparam int DIV_END = 3 + cmc_pkg::LEN_W + cmc_pkg::U_W;
  localparam int LAT     = DIV_END + cmc_pkg::R_W + 9;

  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start};
    end
  end

  assign busy    = 1'b0;
  assign valid_o = vld_q[LAT-1];

  // stage 1: flight vector magnitudes
  logic [cmc_pkg::DW-1:0] dvec [3];
  logic [cmc_pkg::DW-1:0] a1_q [3];
  cmc_pkg::carry_t        c1_q;
  cmc_pkg::carry_t        c1_d;

  always_comb begin
    dvec[0] = {data_i.sv_x[cmc_pkg::POS_WIDTH-1], data_i.sv_x}
            - {data_i.pv_x[cmc_pkg::POS_WIDTH-1], data_i.pv_x};
    dvec[1] = {data_i.sv_y[cmc_pkg::POS_WIDTH-1], data_i.sv_y}
            - {data_i.pv_y[cmc_pkg::POS_WIDTH-1], data_i.pv_y};
    dvec[2] = {data_i.sv_z[cmc_pkg::POS_WIDTH-1], data_i.sv_z}
            - {data_i.pv_z[cmc_pkg::POS_WIDTH-1], data_i.pv_z};
    c1_d.zero = 1'b0;
    c1_d.p[0] = data_i.mom_x;
    c1_d.p[1] = data_i.mom_y;
    c1_d.p[2] = data_i.mom_z;
    c1_d.e    = data_i.energy;
    for (int i = 0; i < 3; i++) begin
      c1_d.neg[i] = dvec[i][cmc_pkg::DW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q <= c1_d;
    for (int i = 0; i < 3; i++) begin
      a1_q[i] <= dvec[i][cmc_pkg::DW-1] ? -dvec[i] : dvec[i];
    end
  end

  // stage 2: normalize so the largest magnitude has its msb at bit 29
  logic [cmc_pkg::DW-1:0]     mx;
  logic [cmc_pkg::MSB_W-1:0]  msb;
  logic [cmc_pkg::DW+cmc_pkg::NORM_W-2:0] wide [3];
  logic [cmc_pkg::NORM_W-1:0] n2_q [3];
  cmc_pkg::carry_t            c2_q;
  cmc_pkg::carry_t            c2_d;

  always_comb begin
    mx = a1_q[0];
    if (a1_q[1] > mx) mx = a1_q[1];
    if (a1_q[2] > mx) mx = a1_q[2];
    msb = '0;
    for (int j = 0; j < cmc_pkg::DW; j++) begin
      if (mx[j]) msb = cmc_pkg::MSB_W'(j);
    end
    for (int i = 0; i < 3; i++) begin
      wide[i] = {a1_q[i], {(cmc_pkg::NORM_W-1){1'b0}}} >> msb;
    end
    c2_d      = c1_q;
    c2_d.zero = (mx == '0);
  end

  always_ff @(posedge clk_i) begin
    c2_q <= c2_d;
    for (int i = 0; i < 3; i++) begin
      n2_q[i] <= wide[i][cmc_pkg::NORM_W-1:0];
    end
  end

  // stage 3 and flight length square root, one root bit per stage
  cmc_pkg::lsq_t lsq_q [cmc_pkg::LEN_W+1];

  always_ff @(posedge clk_i) begin
    lsq_q[0].rem  <= cmc_pkg::L2_W'(n2_q[0]) * cmc_pkg::L2_W'(n2_q[0])
                   + cmc_pkg::L2_W'(n2_q[1]) * cmc_pkg::L2_W'(n2_q[1])
                   + cmc_pkg::L2_W'(n2_q[2]) * cmc_pkg::L2_W'(n2_q[2]);
    lsq_q[0].root <= '0;
    lsq_q[0].c    <= c2_q;
    for (int i = 0; i < 3; i++) begin
      lsq_q[0].n[i] <= n2_q[i];
    end
  end

  for (genvar k = 0; k < cmc_pkg::LEN_W; k++) begin : g_lsqrt
    localparam int B = cmc_pkg::LEN_W - 1 - k;
    logic [cmc_pkg::L2_W+1:0] trial;
    logic                     take;
    cmc_pkg::lsq_t            lsq_d;
    always_comb begin
      trial = ((cmc_pkg::L2_W+2)'(lsq_q[k].root) << (B + 1))
            + ((cmc_pkg::L2_W+2)'(1) << (2 * B));
      take  = {2'b00, lsq_q[k].rem} >= trial;
      lsq_d = lsq_q[k];
      if (take) begin
        lsq_d.rem  = lsq_q[k].rem - trial[cmc_pkg::L2_W-1:0];
        lsq_d.root = lsq_q[k].root | (cmc_pkg::LEN_W'(1) << B);
      end
    end
    always_ff @(posedge clk_i) begin
      lsq_q[k+1] <= lsq_d;
    end
  end

  // unit vector divider, three lanes, one quotient bit per stage
  cmc_pkg::dsq_t dsq_q [cmc_pkg::U_W+1];

  always_ff @(posedge clk_i) begin
    dsq_q[0].len <= lsq_q[cmc_pkg::LEN_W].root;
    dsq_q[0].c   <= lsq_q[cmc_pkg::LEN_W].c;
    dsq_q[0].q   <= '0;
    for (int i = 0; i < 3; i++) begin
      dsq_q[0].rem[i] <= cmc_pkg::DIVW'({lsq_q[cmc_pkg::LEN_W].n[i], {cmc_pkg::UFRAC{1'b0}}})
                       + cmc_pkg::DIVW'(lsq_q[cmc_pkg::LEN_W].root >> 1);
    end
  end

  for (genvar k = 0; k < cmc_pkg::U_W; k++) begin : g_div
    localparam int B = cmc_pkg::UFRAC - k;
    logic [cmc_pkg::DIVW-1:0] dv;
    cmc_pkg::dsq_t            dsq_d;
    always_comb begin
      dv    = cmc_pkg::DIVW'(dsq_q[k].len) << B;
      dsq_d = dsq_q[k];
      for (int i = 0; i < 3; i++) begin
        if (dsq_q[k].rem[i] >= dv) begin
          dsq_d.rem[i] = dsq_q[k].rem[i] - dv;
          dsq_d.q[i]   = dsq_q[k].q[i] | (cmc_pkg::U_W'(1) << B);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      dsq_q[k+1] <= dsq_d;
    end
  end

  // momentum stages
  logic signed [cmc_pkg::U_W:0]      uvec [3];
  logic signed [cmc_pkg::U_W:0]      u_q [3];
  logic signed [cmc_pkg::PR_W-1:0]   pr_q [3];
  logic [2:0][MOM-1:0]               p1_q, p2_q, p3_q;
  logic [MOM-1:0]                    e1_q, e2_q, e3_q, e4_q;
  logic signed [cmc_pkg::U_W:0]      u2_q [3];
  logic signed [cmc_pkg::DD_W-1:0]   dd_q;
  logic signed [cmc_pkg::TP_W-1:0]   tp_q [3];
  logic [cmc_pkg::RM_W-1:0]          rm_q [3];
  logic [MOM-1:0]                    pm_q [3];
  logic [2*cmc_pkg::RM_W-1:0]        rsq_q [3];
  logic [2*MOM-1:0]                  psq_q [3];
  logic [2*MOM-1:0]                  esq_q;
  logic [cmc_pkg::PT2_W-1:0]         pt2_q;
  logic [cmc_pkg::M2_W-1:0]          m2_q;
  logic                              clamp_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dsq_q[cmc_pkg::U_W].c.zero) begin
        uvec[i] = '0;
      end else if (dsq_q[cmc_pkg::U_W].c.neg[i]) begin
        uvec[i] = -$signed({1'b0, dsq_q[cmc_pkg::U_W].q[i]});
      end else begin
        uvec[i] = $signed({1'b0, dsq_q[cmc_pkg::U_W].q[i]});
      end
    end
  end

  // dot product rounding
  logic signed [cmc_pkg::DOT_W-1:0] dot;
  logic [cmc_pkg::DOT_W-1:0]        dmag;
  logic [cmc_pkg::DOT_W-1:0]        dround;
  logic signed [cmc_pkg::DD_W-1:0]  dd_d;

  always_comb begin
    dot = cmc_pkg::DOT_W'(pr_q[0]) + cmc_pkg::DOT_W'(pr_q[1]) + cmc_pkg::DOT_W'(pr_q[2]);
    dmag   = dot[cmc_pkg::DOT_W-1] ? -dot : dot;
    dround = (dmag + (cmc_pkg::DOT_W'(1) << (cmc_pkg::UFRAC - 1))) >> cmc_pkg::UFRAC;
    dd_d   = dot[cmc_pkg::DOT_W-1] ? -$signed(dround[cmc_pkg::DD_W-1:0])
                                   : $signed(dround[cmc_pkg::DD_W-1:0]);
  end

  // perpendicular rest r = p - round(dd * u)
  logic [cmc_pkg::TP_W-1:0]        tmag [3];
  logic [cmc_pkg::TP_W-1:0]        tround [3];
  logic signed [cmc_pkg::TP_W-1:0] rv [3];
  logic [cmc_pkg::TP_W-1:0]        rmag [3];
  logic signed [MOM-1:0]           ps [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ps[i]     = $signed(p3_q[i]);
      tmag[i]   = tp_q[i][cmc_pkg::TP_W-1] ? -tp_q[i] : tp_q[i];
      tround[i] = (tmag[i] + (cmc_pkg::TP_W'(1) << (cmc_pkg::UFRAC - 1))) >> cmc_pkg::UFRAC;
      rv[i]     = cmc_pkg::TP_W'(ps[i])
                - (tp_q[i][cmc_pkg::TP_W-1] ? -$signed(tround[i]) : $signed(tround[i]));
      rmag[i]   = rv[i][cmc_pkg::TP_W-1] ? -rv[i] : rv[i];
    end
  end

  logic [cmc_pkg::P2_W-1:0] p2sum;
  logic [cmc_pkg::P2_W-1:0] e2ext;

  always_comb begin
    p2sum = cmc_pkg::P2_W'(psq_q[0]) + cmc_pkg::P2_W'(psq_q[1]) + cmc_pkg::P2_W'(psq_q[2]);
    e2ext = cmc_pkg::P2_W'(esq_q);
  end

  always_ff @(posedge clk_i) begin
    // P1: u times p
    for (int i = 0; i < 3; i++) begin
      u_q[i]  <= uvec[i];
      pr_q[i] <= uvec[i] * $signed(dsq_q[cmc_pkg::U_W].c.p[i]);
    end
    p1_q <= dsq_q[cmc_pkg::U_W].c.p;
    e1_q <= dsq_q[cmc_pkg::U_W].c.e;
    // P2: projected length
    dd_q <= dd_d;
    p2_q <= p1_q;
    e2_q <= e1_q;
    for (int i = 0; i < 3; i++) begin
      u2_q[i] <= u_q[i];
    end
    // P3: projection per axis
    for (int i = 0; i < 3; i++) begin
      tp_q[i] <= dd_q * u2_q[i];
    end
    p3_q <= p2_q;
    e3_q <= e2_q;
    // P4: rest and momentum magnitudes
    for (int i = 0; i < 3; i++) begin
      rm_q[i] <= rmag[i][cmc_pkg::RM_W-1:0];
      pm_q[i] <= ps[i][MOM-1] ? -p3_q[i] : p3_q[i];
    end
    e4_q <= e3_q;
    // P5: squares
    for (int i = 0; i < 3; i++) begin
      rsq_q[i] <= rm_q[i] * rm_q[i];
      psq_q[i] <= pm_q[i] * pm_q[i];
    end
    esq_q <= e4_q * e4_q;
    // P6: pt squared and clamped mass squared
    pt2_q <= cmc_pkg::PT2_W'(rsq_q[0]) + cmc_pkg::PT2_W'(rsq_q[1])
           + cmc_pkg::PT2_W'(rsq_q[2]);
    if (p2sum > e2ext) begin
      m2_q    <= '0;
      clamp_q <= 1'b1;
    end else begin
      m2_q    <= cmc_pkg::M2_W'(e2ext - p2sum);
      clamp_q <= 1'b0;
    end
  end

  // P7 and the two-lane square root: lane 0 is pt, lane 1 is sqrt(m2 + pt2)
  cmc_pkg::rsq_t rsqp_q [cmc_pkg::R_W+1];

  always_ff @(posedge clk_i) begin
    rsqp_q[0].rem[0]  <= cmc_pkg::X_W'(pt2_q);
    rsqp_q[0].rem[1]  <= cmc_pkg::X_W'(m2_q) + cmc_pkg::X_W'(pt2_q);
    rsqp_q[0].root    <= '0;
    rsqp_q[0].clamped <= clamp_q;
  end

  for (genvar k = 0; k < cmc_pkg::R_W; k++) begin : g_rsqrt
    localparam int B = cmc_pkg::R_W - 1 - k;
    logic [cmc_pkg::X_W+1:0] trial [2];
    cmc_pkg::rsq_t           rsqp_d;
    always_comb begin
      rsqp_d = rsqp_q[k];
      for (int l = 0; l < 2; l++) begin
        trial[l] = ((cmc_pkg::X_W+2)'(rsqp_q[k].root[l]) << (B + 1))
                 + ((cmc_pkg::X_W+2)'(1) << (2 * B));
        if ({2'b00, rsqp_q[k].rem[l]} >= trial[l]) begin
          rsqp_d.rem[l]  = rsqp_q[k].rem[l] - trial[l][cmc_pkg::X_W-1:0];
          rsqp_d.root[l] = rsqp_q[k].root[l] | (cmc_pkg::R_W'(1) << B);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      rsqp_q[k+1] <= rsqp_d;
    end
  end

  // round to nearest, add, saturate
  logic [cmc_pkg::R_W:0]   rnd [2];
  logic [cmc_pkg::R_W+1:0] cm_sum;
  cmc_pkg::out_t           res_d;
  cmc_pkg::out_t           res_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rnd[l] = (cmc_pkg::R_W+1)'(rsqp_q[cmc_pkg::R_W].root[l])
             + (cmc_pkg::R_W+1)'(rsqp_q[cmc_pkg::R_W].rem[l] >
                                 cmc_pkg::X_W'(rsqp_q[cmc_pkg::R_W].root[l]));
    end
    cm_sum = (cmc_pkg::R_W+2)'(rnd[0]) + (cmc_pkg::R_W+2)'(rnd[1]);
    res_d.corrected_mass = (64'(cm_sum) > cmc_pkg::CM_MAX) ? cmc_pkg::CM_MAX[cmc_pkg::CM_W-1:0]
                                                         : 34'(64'(cm_sum));
    res_d.missing_pt     = (64'(rnd[0]) > cmc_pkg::PT_MAX) ? cmc_pkg::PT_MAX[cmc_pkg::PT_W-1:0]
                                                         : 33'(64'(rnd[0]));
    res_d.mass_clamped   = rsqp_q[cmc_pkg::R_W].clamped;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_o = res_q;

  // corrected mass never below missing pt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ({1'b0, result_o.missing_pt} <= result_o.corrected_mass))
    else $error("corrected mass below missing pt");

  // with a clamped mass and an unsaturated missing pt the corrected mass is twice the missing pt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.mass_clamped && (64'(result_o.missing_pt) < cmc_pkg::PT_MAX))
    |-> (result_o.corrected_mass == {result_o.missing_pt, 1'b0}))
    else $error("clamped mass result is not twice missing pt");

  // unit vector components never exceed one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[DIV_END] && !dsq_q[cmc_pkg::U_W].c.zero)
    |-> ((dsq_q[cmc_pkg::U_W].q[0] <= (cmc_pkg::U_W'(1) << cmc_pkg::UFRAC)) &&
         (dsq_q[cmc_pkg::U_W].q[1] <= (cmc_pkg::U_W'(1) << cmc_pkg::UFRAC)) &&
         (dsq_q[cmc_pkg::U_W].q[2] <= (cmc_pkg::U_W'(1) << cmc_pkg::UFRAC))))
    else $error("unit vector component above one");

  // a zero flight vector gives a zero direction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[DIV_END] && dsq_q[cmc_pkg::U_W].c.zero)
    |=> ((u_q[0] == '0) && (u_q[1] == '0) && (u_q[2] == '0)))
    else $error("zero flight length gave nonzero direction");

endmodule
`default_nettype wire
